// ===== design/cbts_pkg.sv =====
// ----------------------------------------------------------------------------
// cbts_pkg: CAN bit timing search package
// Shared types, register indexes and constants for the bit timing search.
// ----------------------------------------------------------------------------
package cbts_pkg;

    localparam int CLK_W   = 28;
    localparam int RATE_W  = 24;
    localparam int DIV_W   = 44;   // remainder / shifted divisor width
    localparam int QUO_W   = 28;   // widest quotient (clock / (brp * tq))
    localparam int STEP_W  = 5;    // divider step counter

    localparam logic [4:0]  TQ_MIN    = 5'd4;
    localparam logic [4:0]  TQ_MAX    = 5'd25;
    localparam logic [9:0]  SP_LOW    = 10'd680;
    localparam logic [9:0]  SP_HIGH   = 10'd875;
    localparam logic [9:0]  SP_TARGET = 10'd800;
    localparam logic [14:0] PERMILLE  = 15'd1000;

    typedef enum logic [2:0] {
        CFG_CLOCK_HZ      = 3'd0,
        CFG_PRESCALER_MIN = 3'd1,
        CFG_PRESCALER_MAX = 3'd2,
        CFG_SEG_ONE_MIN   = 3'd3,
        CFG_SEG_ONE_MAX   = 3'd4,
        CFG_SEG_TWO_MIN   = 3'd5,
        CFG_SEG_TWO_MAX   = 3'd6,
        CFG_JUMP_WIDTH    = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BRP_CHK,
        ST_TQ_START,
        ST_TQ_WAIT,
        ST_TQ_CHK,
        ST_ACT_START,
        ST_ACT_WAIT,
        ST_ERR_CHK,
        ST_T2_CHK,
        ST_SP_WAIT,
        ST_SP_CHK,
        ST_NEXT_BRP,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_item;
        logic calc_d;
        logic start_tq;
        logic latch_tq;
        logic calc_bt;
        logic start_act;
        logic latch_err;
        logic init_t2;
        logic next_t2;
        logic start_sp;
        logic latch_sp;
        logic consider;
        logic next_brp;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic brp_end;
        logic tq_skip;
        logic tq_ok;
        logic err_ok;
        logic t2_end;
        logic t1_ok;
        logic div_done;
        logic out_full;
    } status_t;

endpackage

// ===== design/cbts_if.sv =====
// ----------------------------------------------------------------------------
// cbts_in_if / cbts_out_if: bit timing search channels
// Valid/ready channels for the wanted bitrate and the timing result.
// ----------------------------------------------------------------------------
interface cbts_in_if;
    logic        valid;
    logic        ready;
    logic [23:0] target_bitrate;

    modport source (output valid, output target_bitrate, input ready);
    modport sink   (input valid, input target_bitrate, output ready);
endinterface

interface cbts_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [10:0] prescaler;
    logic        prop_segment;
    logic [4:0]  phase_one;
    logic [4:0]  phase_two;
    logic [7:0]  jump_width;

    modport source (output valid, output found, output prescaler, output prop_segment,
                    output phase_one, output phase_two, output jump_width, input ready);
    modport sink   (input valid, input found, input prescaler, input prop_segment,
                    input phase_one, input phase_two, input jump_width, output ready);
endinterface

// ===== design/cbts_divider.sv =====
// ----------------------------------------------------------------------------
// cbts_divider: iterative restoring divider
// One quotient bit per cycle; the divisor arrives pre-shifted to the top bit.
// ----------------------------------------------------------------------------
module cbts_divider
    import cbts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_W-1:0]  num,
    input  logic [DIV_W-1:0]  den,
    input  logic [STEP_W-1:0] steps,
    output logic              busy,
    output logic              done,
    output logic [QUO_W-1:0]  quo
);

    logic [DIV_W-1:0]  rem_reg, rem_next;
    logic [DIV_W-1:0]  dvs_reg, dvs_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            dvs_next  = den;
            quo_next  = '0;
            cnt_next  = steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dvs_reg)
            begin
                rem_next = rem_reg - dvs_reg;
                quo_next = {quo_reg[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quo_next = {quo_reg[QUO_W-2:0], 1'b0};
            end
            dvs_next = dvs_reg >> 1;
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ===== design/cbts_datapath.sv =====
// ----------------------------------------------------------------------------
// cbts_datapath: bit timing search datapath
// Config registers, candidate arithmetic, best-candidate tracking, result.
// ----------------------------------------------------------------------------
module cbts_datapath
    import cbts_pkg::*;
#(
    parameter int PRESCALER_STEP = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [2:0]        cfg_index,
    input  logic [CLK_W-1:0]  cfg_data,
    input  logic [RATE_W-1:0] target_bitrate,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              found,
    output logic [10:0]       prescaler,
    output logic              prop_segment,
    output logic [4:0]        phase_one,
    output logic [4:0]        phase_two,
    output logic [7:0]        jump_width
);

    localparam int BRP_W = $clog2(2048 + PRESCALER_STEP);

    logic [CLK_W-1:0]  clock_hz_reg;
    logic [10:0]       pmin_reg, pmax_reg;
    logic [8:0]        s1min_reg, s1max_reg;
    logic [7:0]        s2min_reg, s2max_reg, sjw_reg;

    logic [RATE_W-1:0] rate_reg;
    logic [BRP_W-1:0]  brp_reg;
    logic [34:0]       d_reg;
    logic [4:0]        tq_reg;
    logic [15:0]       bt_reg;
    logic [27:0]       err_reg;
    logic [7:0]        t2_reg;
    logic [9:0]        sp_reg;

    logic              have_reg;
    logic [27:0]       b_err_reg;
    logic [9:0]        b_ds_reg;
    logic [4:0]        b_tq_reg;
    logic [10:0]       b_brp_reg;
    logic [4:0]        b_t1_reg;
    logic [4:0]        b_t2_reg;

    logic              out_full_reg;
    logic              found_reg;
    logic [10:0]       prescaler_reg;
    logic [4:0]        phase_one_reg, phase_two_reg;
    logic [7:0]        jump_width_reg;

    logic [40:0]       d63, clk2;
    logic [35:0]       tq_sum;
    logic [4:0]        t1;
    logic [14:0]       sp_num;
    logic [9:0]        ds;
    logic              sp_ok, better;
    logic [27:0]       actual, err_new;

    logic              div_start, div_busy, div_done;
    logic [DIV_W-1:0]  div_num, div_den;
    logic [STEP_W-1:0] div_steps;
    logic [QUO_W-1:0]  div_quo;

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= 28'd48000000;
            pmin_reg     <= 11'd1;
            pmax_reg     <= 11'd1024;
            s1min_reg    <= 9'd1;
            s1max_reg    <= 9'd16;
            s2min_reg    <= 8'd1;
            s2max_reg    <= 8'd8;
            sjw_reg      <= 8'd4;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLOCK_HZ:      clock_hz_reg <= cfg_data;
                CFG_PRESCALER_MIN: pmin_reg     <= cfg_data[10:0];
                CFG_PRESCALER_MAX: pmax_reg     <= cfg_data[10:0];
                CFG_SEG_ONE_MIN:   s1min_reg    <= cfg_data[8:0];
                CFG_SEG_ONE_MAX:   s1max_reg    <= cfg_data[8:0];
                CFG_SEG_TWO_MIN:   s2min_reg    <= cfg_data[7:0];
                CFG_SEG_TWO_MAX:   s2max_reg    <= cfg_data[7:0];
                CFG_JUMP_WIDTH:    sjw_reg      <= cfg_data[7:0];
                default:           ;
            endcase
        end
    end

    // quanta = (2*clk + d) / (2*d); overflow past 31 when 2*clk >= 63*d
    assign d63    = {d_reg, 6'b0} - {6'b0, d_reg};
    assign clk2   = {12'b0, clock_hz_reg, 1'b0};
    assign tq_sum = {7'b0, clock_hz_reg, 1'b0} + {1'b0, d_reg};
    assign t1     = tq_reg - 5'd1 - t2_reg[4:0];
    assign sp_num = 15'(tq_reg - t2_reg[4:0]) * PERMILLE;

    assign actual  = div_quo;
    assign err_new = (actual > 28'(rate_reg)) ? actual - 28'(rate_reg)
                                               : 28'(rate_reg) - actual;

    assign sp_ok = (sp_reg >= SP_LOW) && (sp_reg <= SP_HIGH);
    assign ds    = (sp_reg > SP_TARGET) ? sp_reg - SP_TARGET : SP_TARGET - sp_reg;

    always_comb
    begin
        if (!have_reg)
            better = 1'b1;
        else if (err_reg != b_err_reg)
            better = err_reg < b_err_reg;
        else if (ds != b_ds_reg)
            better = ds < b_ds_reg;
        else
            better = tq_reg > b_tq_reg;
    end

    // divider operand select
    assign div_start = cmd.start_tq | cmd.start_act | cmd.start_sp;

    always_comb
    begin
        div_num   = {8'b0, tq_sum};
        div_den   = {4'b0, d_reg, 5'b0};
        div_steps = STEP_W'(5);
        if (cmd.start_act)
        begin
            div_num   = {16'b0, clock_hz_reg};
            div_den   = {1'b0, bt_reg, 27'b0};
            div_steps = STEP_W'(28);
        end
        else if (cmd.start_sp)
        begin
            div_num   = {29'b0, sp_num};
            div_den   = {30'b0, tq_reg, 9'b0};
            div_steps = STEP_W'(10);
        end
    end

    cbts_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .steps (div_steps),
        .busy  (div_busy),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rate_reg <= target_bitrate;
            brp_reg  <= BRP_W'(pmin_reg);
        end
        if (cmd.next_brp)
            brp_reg <= brp_reg + BRP_W'(PRESCALER_STEP);
        if (cmd.calc_d)
            d_reg <= 35'(brp_reg[10:0]) * 35'(rate_reg);
        if (cmd.latch_tq)
            tq_reg <= div_quo[4:0];
        if (cmd.calc_bt)
            bt_reg <= 16'(brp_reg[10:0]) * 16'(tq_reg);
        if (cmd.latch_err)
            err_reg <= err_new;
        if (cmd.init_t2)
            t2_reg <= s2min_reg;
        if (cmd.next_t2)
            t2_reg <= t2_reg + 8'd1;
        if (cmd.latch_sp)
            sp_reg <= div_quo[9:0];
        if (cmd.consider && sp_ok && better)
        begin
            b_err_reg <= err_reg;
            b_ds_reg  <= ds;
            b_tq_reg  <= tq_reg;
            b_brp_reg <= brp_reg[10:0];
            b_t1_reg  <= t1;
            b_t2_reg  <= t2_reg[4:0];
        end
        if (cmd.load_out)
        begin
            found_reg      <= have_reg;
            prescaler_reg  <= have_reg ? b_brp_reg : 11'd0;
            phase_one_reg  <= have_reg ? b_t1_reg - 5'd1 : 5'd0;
            phase_two_reg  <= have_reg ? b_t2_reg : 5'd0;
            jump_width_reg <= have_reg ? sjw_reg : 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
                have_reg <= 1'b0;
            else if (cmd.consider && sp_ok)
                have_reg <= 1'b1;
            if (cmd.load_out)
                out_full_reg <= 1'b1;
            else if (out_full_reg && out_ready)
                out_full_reg <= 1'b0;
        end
    end

    assign status.brp_end  = brp_reg > BRP_W'(pmax_reg);
    assign status.tq_skip  = (d_reg == 35'd0) || (clk2 >= d63);
    assign status.tq_ok    = (tq_reg >= TQ_MIN) && (tq_reg <= TQ_MAX);
    assign status.err_ok   = (38'(err_reg) * 38'd1000) <= 38'(rate_reg);
    assign status.t2_end   = (t2_reg > s2max_reg) || (t2_reg >= {3'b0, tq_reg});
    assign status.t1_ok    = ({4'b0, t1} >= s1min_reg) && ({4'b0, t1} <= s1max_reg);
    assign status.div_done = div_done;
    assign status.out_full = out_full_reg;

    assign out_valid    = out_full_reg;
    assign found        = found_reg;
    assign prescaler    = prescaler_reg;
    assign prop_segment = found_reg;
    assign phase_one    = phase_one_reg;
    assign phase_two    = phase_two_reg;
    assign jump_width   = jump_width_reg;

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_full_reg && !found_reg) |->
        (prescaler_reg == 11'd0 && phase_two_reg == 5'd0 && jump_width_reg == 8'd0))
        else $error("empty result carries nonzero timing");

    a_div_idle_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_best_tq_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(have_reg) |-> (b_tq_reg >= TQ_MIN && b_tq_reg <= TQ_MAX))
        else $error("best candidate quanta out of range");

endmodule

// ===== design/cbts_ctrl.sv =====
// ----------------------------------------------------------------------------
// cbts_ctrl: bit timing search controller
// Walks prescalers and phase-two lengths, sequencing the shared divider.
// ----------------------------------------------------------------------------
module cbts_ctrl
    import cbts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_BRP_CHK;
                end
            end
            ST_BRP_CHK:
            begin
                if (status.brp_end)
                    state_next = ST_FINISH;
                else
                begin
                    cmd.calc_d = 1'b1;
                    state_next = ST_TQ_START;
                end
            end
            ST_TQ_START:
            begin
                if (status.tq_skip)
                    state_next = ST_NEXT_BRP;
                else
                begin
                    cmd.start_tq = 1'b1;
                    state_next   = ST_TQ_WAIT;
                end
            end
            ST_TQ_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_tq = 1'b1;
                    state_next   = ST_TQ_CHK;
                end
            end
            ST_TQ_CHK:
            begin
                if (!status.tq_ok)
                    state_next = ST_NEXT_BRP;
                else
                begin
                    cmd.calc_bt = 1'b1;
                    state_next  = ST_ACT_START;
                end
            end
            ST_ACT_START:
            begin
                cmd.start_act = 1'b1;
                state_next    = ST_ACT_WAIT;
            end
            ST_ACT_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_err = 1'b1;
                    state_next    = ST_ERR_CHK;
                end
            end
            ST_ERR_CHK:
            begin
                if (!status.err_ok)
                    state_next = ST_NEXT_BRP;
                else
                begin
                    cmd.init_t2 = 1'b1;
                    state_next  = ST_T2_CHK;
                end
            end
            ST_T2_CHK:
            begin
                if (status.t2_end)
                    state_next = ST_NEXT_BRP;
                else if (!status.t1_ok)
                    cmd.next_t2 = 1'b1;
                else
                begin
                    cmd.start_sp = 1'b1;
                    state_next   = ST_SP_WAIT;
                end
            end
            ST_SP_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.latch_sp = 1'b1;
                    state_next   = ST_SP_CHK;
                end
            end
            ST_SP_CHK:
            begin
                cmd.consider = 1'b1;
                cmd.next_t2  = 1'b1;
                state_next   = ST_T2_CHK;
            end
            ST_NEXT_BRP:
            begin
                cmd.next_brp = 1'b1;
                state_next   = ST_BRP_CHK;
            end
            ST_FINISH:
            begin
                // hold until the previous result has left the output register
                if (!status.out_full)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> !status.out_full)
        else $error("result overwritten before transaction completed");

endmodule

// ===== design/can_bit_timing_search_unit.sv =====
// ----------------------------------------------------------------------------
// can_bit_timing_search_unit: CAN bit timing search
// Finds prescaler and segment lengths for a wanted CAN bitrate.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the wanted bitrate; one transaction is taken when the unit
//   is idle. out_ch returns one result per input: found flag, prescaler,
//   propagation segment, phase one, phase two and jump width.
//   Configuration is written through cfg_we/cfg_index/cfg_data; the user
//   must write it only while idle, which the unit does not enforce.
// Search: per prescaler, the quanta division unless it is skipped; if the
//   quanta are in range, the bitrate division; if the error is small
//   enough, each phase-two length (at most 25 lengths) is tried and the
//   sample point division runs for each one that passes the segment one
//   check. Bounded by the iterative divider, one quotient bit per cycle,
//   shared by all three divisions.
// Throughput: one item per search; the next item is taken once the result
//   has been written to the output register.
// Reset: configuration returns to its defaults, the controller goes idle and
//   the output register empties.
// Stall: a held result stays in the output register; a finished search
//   waits until it has been taken.
// ----------------------------------------------------------------------------
module can_bit_timing_search_unit
    import cbts_pkg::*;
#(
    parameter int PRESCALER_STEP = 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_index,
    input  logic [CLK_W-1:0] cfg_data,
    cbts_in_if.sink          in_ch,
    cbts_out_if.source       out_ch
);

    cmd_t    cmd;
    status_t status;

    cbts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    cbts_datapath #(
        .PRESCALER_STEP (PRESCALER_STEP)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .target_bitrate (in_ch.target_bitrate),
        .cmd            (cmd),
        .status         (status),
        .out_ready      (out_ch.ready),
        .out_valid      (out_ch.valid),
        .found          (out_ch.found),
        .prescaler      (out_ch.prescaler),
        .prop_segment   (out_ch.prop_segment),
        .phase_one      (out_ch.phase_one),
        .phase_two      (out_ch.phase_two),
        .jump_width     (out_ch.jump_width)
    );

endmodule

// ===== dv/can_bit_timing_search_unit_test.sv =====
// ----------------------------------------------------------------------------
// can_bit_timing_search_unit_test: bit timing search testbench
// Drives wanted bitrates under several register settings, predicts the
// chosen timing with an in-bench search and compares every result field.
// ----------------------------------------------------------------------------
module can_bit_timing_search_unit_test;
    import cbts_pkg::*;

    typedef struct packed {
        logic        found;
        logic [10:0] prescaler;
        logic        prop_segment;
        logic [4:0]  phase_one;
        logic [4:0]  phase_two;
        logic [7:0]  jump_width;
    } timing_t;

    localparam longint CYCLE_LIMIT = 40000000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [27:0] cfg_data;

    cbts_in_if  in_ch ();
    cbts_out_if out_ch ();

    can_bit_timing_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // register mirror
    logic [27:0] m_clock_hz;
    logic [10:0] m_brp_min;
    logic [10:0] m_brp_max;
    logic [8:0]  m_seg1_min;
    logic [8:0]  m_seg1_max;
    logic [7:0]  m_seg2_min;
    logic [7:0]  m_seg2_max;
    logic [7:0]  m_sjw;

    logic [23:0] rate_q[$];
    timing_t     timing_q[$];
    int          send_idle;
    int          recv_idle;
    int          mismatches;
    bit          hold_go;
    bit          hold_done;
    int          hold_left;
    longint      cycles;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic timing_t search_timing(logic [23:0] rate_in);
        longint unsigned rate;
        longint unsigned clkv;
        longint unsigned lim;
        longint unsigned d;
        longint unsigned tq;
        longint unsigned act;
        longint unsigned err;
        int unsigned     brp;
        int unsigned     t1;
        int unsigned     t2;
        int unsigned     sp;
        int unsigned     ds;
        bit              have;
        bit              better;
        int unsigned     b_err;
        int unsigned     b_dist;
        int unsigned     b_tq;
        int unsigned     b_brp;
        int unsigned     b_t1;
        int unsigned     b_t2;
        timing_t         res;
        rate = rate_in;
        clkv = m_clock_hz;
        lim = rate / 1000;
        have = 0;
        b_err = 0; b_dist = 0; b_tq = 0; b_brp = 0; b_t1 = 0; b_t2 = 0;
        for (brp = m_brp_min; brp <= m_brp_max; brp++) begin
            d = longint'(brp) * rate;
            if (d == 0)
                continue;
            tq = (2 * clkv + d) / (2 * d);
            if (tq < 4 || tq > 25)
                continue;
            act = clkv / (longint'(brp) * tq);
            err = act > rate ? act - rate : rate - act;
            if (err > lim)
                continue;
            for (t2 = m_seg2_min; t2 <= m_seg2_max && t2 < tq; t2++) begin
                t1 = int'(tq) - 1 - t2;
                if (t1 < m_seg1_min || t1 > m_seg1_max)
                    continue;
                sp = (1 + t1) * 1000 / int'(tq);
                if (sp < 680 || sp > 875)
                    continue;
                ds = sp > 800 ? sp - 800 : 800 - sp;
                if (!have)
                    better = 1;
                else if (int'(err) != b_err)
                    better = int'(err) < b_err;
                else if (ds != b_dist)
                    better = ds < b_dist;
                else
                    better = int'(tq) > b_tq;
                if (better) begin
                    have = 1;
                    b_err = int'(err);
                    b_dist = ds;
                    b_tq = int'(tq);
                    b_brp = brp;
                    b_t1 = t1;
                    b_t2 = t2;
                end
            end
        end
        res = '0;
        if (have) begin
            res.found = 1'b1;
            res.prescaler = b_brp[10:0];
            res.prop_segment = 1'b1;
            res.phase_one = 5'(b_t1 - 1);
            res.phase_two = b_t2[4:0];
            res.jump_width = m_sjw;
        end
        return res;
    endfunction

    task automatic write_reg(cfg_idx_t idx, logic [27:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            CFG_CLOCK_HZ:      m_clock_hz = val;
            CFG_PRESCALER_MIN: m_brp_min = val[10:0];
            CFG_PRESCALER_MAX: m_brp_max = val[10:0];
            CFG_SEG_ONE_MIN:   m_seg1_min = val[8:0];
            CFG_SEG_ONE_MAX:   m_seg1_max = val[8:0];
            CFG_SEG_TWO_MIN:   m_seg2_min = val[7:0];
            CFG_SEG_TWO_MAX:   m_seg2_max = val[7:0];
            default:           m_sjw = val[7:0];
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_timing_regs(logic [27:0] c, int bmin, int bmax, int s1a, int s1b,
                                   int s2a, int s2b, int sjw);
        write_reg(CFG_CLOCK_HZ, c);
        write_reg(CFG_PRESCALER_MIN, 28'(bmin));
        write_reg(CFG_PRESCALER_MAX, 28'(bmax));
        write_reg(CFG_SEG_ONE_MIN, 28'(s1a));
        write_reg(CFG_SEG_ONE_MAX, 28'(s1b));
        write_reg(CFG_SEG_TWO_MIN, 28'(s2a));
        write_reg(CFG_SEG_TWO_MAX, 28'(s2b));
        write_reg(CFG_JUMP_WIDTH, 28'(sjw));
    endtask

    task automatic drain();
        while (rate_q.size() != 0 || in_ch.valid || timing_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // bitrate that mostly lands near a real prescaler/quanta combination, else random
    function automatic logic [23:0] near_rate();
        longint unsigned brp;
        longint unsigned tq;
        longint unsigned base;
        longint unsigned lo;
        longint unsigned hi;
        lo = m_brp_min == 0 ? 1 : m_brp_min;
        hi = m_brp_max < lo ? lo : m_brp_max;
        brp = $urandom_range(int'(hi), int'(lo));
        tq = $urandom_range(25, 4);
        base = longint'(m_clock_hz) / (brp * tq);
        if (base == 0 || $urandom_range(9) == 0)
            return 24'($urandom);
        base = base * (998 + $urandom_range(4)) / 1000;
        return base > 24'hFFFFFF ? 24'($urandom) : 24'(base);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.target_bitrate <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid)
                timing_q.push_back(search_timing(in_ch.target_bitrate));
            if (rate_q.size() != 0 && $urandom_range(99) >= send_idle) begin
                in_ch.valid <= 1'b1;
                in_ch.target_bitrate <= rate_q.pop_front();
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_left <= 6000;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin
        timing_t got;
        timing_t want;
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.found = out_ch.found;
                got.prescaler = out_ch.prescaler;
                got.prop_segment = out_ch.prop_segment;
                got.phase_one = out_ch.phase_one;
                got.phase_two = out_ch.phase_two;
                got.jump_width = out_ch.jump_width;
                if (timing_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %p", got);
                end else begin
                    want = timing_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result differs: expected %p actual %p", want, got);
                    end
                end
            end
            out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("can_bit_timing_search_unit: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [23:0] fixed_rates[12];
        cycles = 0;
        mismatches = 0;
        hold_go = 1'b0;
        send_idle = 27;
        recv_idle = 48;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CLOCK_HZ;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.target_bitrate = '0;
        out_ch.ready = 1'b0;
        m_clock_hz = 28'd48000000;
        m_brp_min = 11'd1;
        m_brp_max = 11'd1024;
        m_seg1_min = 9'd1;
        m_seg1_max = 9'd16;
        m_seg2_min = 8'd1;
        m_seg2_max = 8'd8;
        m_sjw = 8'd4;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, full prescaler range
        fixed_rates = '{24'd0, 24'd1, 24'd16000000, 24'hFFFFFF, 24'd1000000, 24'd500000,
                        24'd250000, 24'd125000, 24'd83333, 24'd10000, 24'd800000,
                        24'd33333};
        foreach (fixed_rates[i])
            rate_q.push_back(fixed_rates[i]);
        drain();

        for (int ph = 0; ph < 9; ph++) begin
            send_idle = ph < 3 ? 27 : (ph < 6 ? 48 : 0);
            recv_idle = ph < 3 ? 48 : (ph < 6 ? 27 : 0);
            case (ph)
                0: set_timing_regs(28'd80000000, 1, 40, 1, 256, 1, 128, 128);
                1: set_timing_regs(28'hFFFFFFF, 1000, 1024, 4, 8, 2, 4, 1);
                2: set_timing_regs(28'd1, 1024, 1, 0, 0, 0, 0, 255);
                3: set_timing_regs(28'd40000000, 0, 20, 0, 511, 0, 255, 7);
                4: set_timing_regs(28'd16000000, 1, 16, 2, 12, 1, 8, 3);
                5: set_timing_regs(28'd48000000, 1, 1024, 1, 16, 1, 8, 4);
                6: set_timing_regs(28'd8000000, 1, 8, 3, 15, 2, 6, 2);
                default: set_timing_regs(28'($urandom_range(100000000, 1000000)),
                                         $urandom_range(30, 1), $urandom_range(60, 20),
                                         $urandom_range(4, 1), $urandom_range(24, 8),
                                         $urandom_range(3, 1), $urandom_range(10, 4),
                                         $urandom_range(128, 1));
            endcase
            // full range phase is slow, keep it short
            for (int n = 0; n < (ph == 5 ? 3 : 11); n++)
                rate_q.push_back(near_rate());
            if (ph == 4)
                hold_go = 1'b1;
            drain();
        end

        if (mismatches == 0)
            $display("can_bit_timing_search_unit: match");
        else
            $display("can_bit_timing_search_unit: mismatch");
        $finish;
    end

endmodule
